// ===== rtl/ztf_pkg.sv =====
`default_nettype none
package ztf_pkg;
  localparam int MaxItemsDef   = 32;
  localparam int ValueWidthDef = 16;
  localparam int MaxTriplesDef = 64;
  localparam int VW = ValueWidthDef;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic signed [VW-1:0] first;
    logic signed [VW-1:0] second;
    logic signed [VW-1:0] third;
    logic                 found;
    logic                 overflow;
    logic                 final_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_KEY, ST_SORT_CMP, ST_ANCHOR, ST_RD_A, ST_PTR,
    ST_RD_L, ST_RD_R, ST_CMP, ST_SKIP_L, ST_SKIP_R, ST_DONE
  } ztf_state_t;
endpackage
`default_nettype wire

// ===== rtl/ztf_res_fifo.sv =====
`default_nettype none
module ztf_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  ztf_pkg::out_item_t     wr_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ztf_pkg::out_item_t     out_data
);
  import ztf_pkg::*;
  out_item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic rd_en;

  assign full      = cnt_r == 3'd4;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem_r[rp_r];
  assign rd_en     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en && !full} - {2'd0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ztf_core.sv =====
`default_nettype none
module ztf_core #(
  parameter int MAX_ITEMS   = ztf_pkg::MaxItemsDef,
  parameter int MAX_TRIPLES = ztf_pkg::MaxTriplesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  ztf_pkg::in_item_t      in_data,
  output logic                   res_wr,
  output ztf_pkg::out_item_t     res_data,
  input  wire logic              res_full
);
  import ztf_pkg::*;
  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CW1 = CW + 1;
  localparam int TW  = $clog2(MAX_TRIPLES + 2);

  logic signed [VW-1:0] mem_r [MAX_ITEMS];
  logic signed [VW-1:0] rd_r;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  logic signed [VW-1:0] wd;

  ztf_state_t st_r, st_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          drop_r, drop_nxt;
  logic          pass_r, pass_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, l_r, l_nxt, r_r, r_nxt;
  logic signed [VW-1:0] key_r, key_nxt, a_r, a_nxt, lv_r, lv_nxt, rv_r, rv_nxt;
  logic signed [VW-1:0] prev_r, prev_nxt;
  logic          havep_r, havep_nxt;
  logic [TW-1:0] tot_r, tot_nxt, ecnt_r, ecnt_nxt;
  logic [TW-1:0] emit_tot;
  logic signed [VW+1:0] s3;
  logic          last_emit;
  logic          anchor_end;
  logic          shift;
  logic          skip_l;
  logic          skip_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    rd_r <= mem_r[ra];
  end

  assign s3 = {{2{a_r[VW-1]}}, a_r} + {{2{lv_r[VW-1]}}, lv_r}
            + {{2{rv_r[VW-1]}}, rv_r};
  assign emit_tot   = (tot_r > TW'(MAX_TRIPLES)) ? TW'(MAX_TRIPLES) : tot_r;
  assign last_emit  = (ecnt_r + TW'(1)) == emit_tot;
  assign anchor_end = ({1'b0, i_r} + CW1'(2)) >= {1'b0, n_r};
  assign shift      = j_r != '0 && rd_r > key_r;
  assign skip_l     = l_r < r_r && rd_r == lv_r;
  assign skip_r     = l_r < r_r && rd_r == rv_r;

  // first search pass counts triples, second pass emits them
  always_comb begin
    st_nxt = st_r; n_nxt = n_r; drop_nxt = drop_r; pass_nxt = pass_r;
    i_nxt = i_r; j_nxt = j_r; l_nxt = l_r; r_nxt = r_r; key_nxt = key_r;
    a_nxt = a_r; lv_nxt = lv_r; rv_nxt = rv_r; prev_nxt = prev_r;
    havep_nxt = havep_r; tot_nxt = tot_r; ecnt_nxt = ecnt_r;
    unique case (st_r)
      ST_LOAD: if (in_valid) begin
        if (n_r < CW'(MAX_ITEMS)) n_nxt = n_r + CW'(1);
        else drop_nxt = 1'b1;
        if (in_data.last) begin
          st_nxt = ST_SORT_RD; i_nxt = CW'(1); tot_nxt = '0; pass_nxt = 1'b0;
        end
      end
      ST_SORT_RD: begin
        if (i_r >= n_r) begin
          st_nxt = ST_ANCHOR; i_nxt = '0; havep_nxt = 1'b0;
        end else begin
          j_nxt = i_r; st_nxt = ST_SORT_KEY;
        end
      end
      ST_SORT_KEY: begin
        key_nxt = rd_r; st_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (shift) j_nxt = j_r - CW'(1);
        else begin
          i_nxt = i_r + CW'(1); st_nxt = ST_SORT_RD;
        end
      end
      ST_ANCHOR: begin
        if (!anchor_end) st_nxt = ST_RD_A;
        else if (!pass_r && tot_r != '0) begin
          pass_nxt = 1'b1; i_nxt = '0; havep_nxt = 1'b0; ecnt_nxt = '0;
        end else st_nxt = ST_DONE;
      end
      ST_RD_A: begin
        if (havep_r && rd_r == prev_r) begin
          i_nxt = i_r + CW'(1); st_nxt = ST_ANCHOR;
        end else begin
          a_nxt = rd_r; prev_nxt = rd_r; havep_nxt = 1'b1;
          l_nxt = i_r + CW'(1); r_nxt = n_r - CW'(1); st_nxt = ST_PTR;
        end
      end
      ST_PTR: begin
        if (l_r < r_r) st_nxt = ST_RD_L;
        else begin
          i_nxt = i_r + CW'(1); st_nxt = ST_ANCHOR;
        end
      end
      ST_RD_L: begin
        lv_nxt = rd_r; st_nxt = ST_RD_R;
      end
      ST_RD_R: begin
        rv_nxt = rd_r; st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (s3 < 0) begin
          l_nxt = l_r + CW'(1); st_nxt = ST_PTR;
        end else if (s3 > 0) begin
          r_nxt = r_r - CW'(1); st_nxt = ST_PTR;
        end else if (!pass_r) begin
          if (tot_r <= TW'(MAX_TRIPLES)) tot_nxt = tot_r + TW'(1);
          l_nxt = l_r + CW'(1); r_nxt = r_r - CW'(1); st_nxt = ST_SKIP_L;
        end else if (!res_full) begin
          ecnt_nxt = ecnt_r + TW'(1);
          if (last_emit) st_nxt = ST_DONE;
          else begin
            l_nxt = l_r + CW'(1); r_nxt = r_r - CW'(1); st_nxt = ST_SKIP_L;
          end
        end
      end
      ST_SKIP_L: begin
        if (skip_l) l_nxt = l_r + CW'(1);
        else st_nxt = ST_SKIP_R;
      end
      ST_SKIP_R: begin
        if (skip_r) r_nxt = r_r - CW'(1);
        else st_nxt = ST_PTR;
      end
      ST_DONE: if (tot_r != '0 || !res_full) begin
        st_nxt = ST_LOAD; n_nxt = '0; drop_nxt = 1'b0; pass_nxt = 1'b0;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // memory address and side effects per state
  always_comb begin
    we = 1'b0; wa = n_r[AW-1:0]; wd = in_data.value; ra = '0;
    in_ready = 1'b0; res_wr = 1'b0; res_data = '0;
    unique case (st_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        we = in_valid && n_r < CW'(MAX_ITEMS);
      end
      ST_SORT_RD: ra = i_r[AW-1:0];
      ST_SORT_KEY: ra = AW'(j_r - CW'(1));
      ST_SORT_CMP: begin
        we = 1'b1;
        wa = j_r[AW-1:0];
        if (shift) begin
          wd = rd_r; ra = AW'(j_r - CW'(2));
        end else wd = key_r;
      end
      ST_ANCHOR: ra = i_r[AW-1:0];
      ST_RD_A: ;
      ST_PTR: ra = l_r[AW-1:0];
      ST_RD_L: ra = r_r[AW-1:0];
      ST_RD_R: ;
      ST_CMP: begin
        ra = AW'(l_r + CW'(1));
        if (pass_r && s3 == 0 && !res_full) begin
          res_wr = 1'b1;
          res_data.first = a_r; res_data.second = lv_r; res_data.third = rv_r;
          res_data.found = 1'b1;
          res_data.overflow = drop_r || tot_r > TW'(MAX_TRIPLES);
          res_data.final_res = last_emit;
        end
      end
      ST_SKIP_L: ra = skip_l ? AW'(l_r + CW'(1)) : r_r[AW-1:0];
      ST_SKIP_R: ra = AW'(r_r - CW'(1));
      ST_DONE: if (tot_r == '0 && !res_full) begin
        res_wr = 1'b1;
        res_data.overflow = drop_r || tot_r > TW'(MAX_TRIPLES);
        res_data.final_res = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; n_r <= '0; drop_r <= 1'b0; pass_r <= 1'b0;
      havep_r <= 1'b0; tot_r <= '0; ecnt_r <= '0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; drop_r <= drop_nxt; pass_r <= pass_nxt;
      havep_r <= havep_nxt; tot_r <= tot_nxt; ecnt_r <= ecnt_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; l_r <= l_nxt; r_r <= r_nxt; key_r <= key_nxt;
    a_r <= a_nxt; prev_r <= prev_nxt; lv_r <= lv_nxt; rv_r <= rv_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/zero_sum_triple_finder.sv =====
`default_nettype none
// Zero-sum triple finder.
// Input channel in_valid/in_ready/in_data carries one set element per
// transfer; in_data.last closes the set. Loading takes one cycle per element.
// After the last element the set is sorted in place (insertion sort over the
// element memory). The two-pointer search then runs once to count the
// triples and, if any were found, once more to emit them. Each zero-sum
// triple, up to MAX_TRIPLES per run, is written into a 4-entry result queue
// and shows on out_valid/out_ready/out_data in the next cycle. A run with no
// triple yields one result with found low; final_res marks the last result
// of a run. in_ready stays low from the last element until the run's final
// result is queued. A stalled receiver fills the queue and then holds the
// search. Synchronous reset on rst_n empties the set and the queue.
module zero_sum_triple_finder #(
  parameter int MAX_ITEMS   = ztf_pkg::MaxItemsDef,
  parameter int MAX_TRIPLES = ztf_pkg::MaxTriplesDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ztf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ztf_pkg::out_item_t out_data
);
  import ztf_pkg::*;
  logic      res_wr, res_full;
  out_item_t res_data;

  ztf_core #(.MAX_ITEMS(MAX_ITEMS), .MAX_TRIPLES(MAX_TRIPLES)) u_core (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .res_wr, .res_data, .res_full
  );

  ztf_res_fifo u_fifo (
    .clk, .rst_n, .wr_en(res_wr), .wr_data(res_data), .full(res_full),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

// ===== test/zero_sum_triple_finder_checker.sv =====
`timescale 1ns / 1ps
module zero_sum_triple_finder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ztf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ztf_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_triples,
  output int                 triples_seen,
  output int                 sets_closed
);
  import ztf_pkg::*;

  localparam int SetDepth = MaxItemsDef;
  localparam int TripleCap = MaxTriplesDef;

  logic signed [VW-1:0] set_vals[SetDepth];
  int                   set_len;
  logic                 set_dropped;
  out_item_t            triple_q[$];

  task automatic close_set();
    logic signed [VW-1:0] s[$];
    logic signed [VW-1:0] key;
    out_item_t            found_q[$];
    out_item_t            r;
    int                   total;
    int                   j;
    int                   lo;
    int                   hi;
    int                   emit;
    longint               sum;
    logic                 ovf;
    total = 0;
    for (int i = 0; i < set_len; i++) s.insert(s.size(), set_vals[i]);
    for (int i = 1; i < s.size(); i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    for (int i = 0; i + 2 < s.size(); i++) begin
      if (i > 0 && s[i] == s[i-1]) continue;
      lo = i + 1;
      hi = s.size() - 1;
      while (lo < hi) begin
        sum = longint'(s[i]) + longint'(s[lo]) + longint'(s[hi]);
        if (sum < 0) lo++;
        else if (sum > 0) hi--;
        else begin
          if (total < TripleCap) begin
            r = '0;
            r.first = s[i];
            r.second = s[lo];
            r.third = s[hi];
            r.found = 1'b1;
            found_q.insert(found_q.size(), r);
          end
          total++;
          lo++;
          hi--;
          while (lo < hi && s[lo] == s[lo-1]) lo++;
          while (lo < hi && s[hi] == s[hi+1]) hi--;
        end
      end
    end
    ovf = set_dropped || total > TripleCap;
    if (total == 0) begin
      r = '0;
      found_q.insert(found_q.size(), r);
    end
    emit = found_q.size();
    for (int k = 0; k < emit; k++) begin
      r = found_q[k];
      r.overflow = ovf;
      r.final_res = (k == emit - 1);
      triple_q.insert(triple_q.size(), r);
    end
    set_len = 0;
    set_dropped = 1'b0;
    sets_closed++;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (triple_q.size() == 0) begin
      $error("unexpected result %p", got);
      fail_count++;
      return;
    end
    want = triple_q.pop_front();
    if (got.first !== want.first) begin
      $error("first: expected %0d, got %0d", want.first, got.first);
      fail_count++;
    end
    if (got.second !== want.second) begin
      $error("second: expected %0d, got %0d", want.second, got.second);
      fail_count++;
    end
    if (got.third !== want.third) begin
      $error("third: expected %0d, got %0d", want.third, got.third);
      fail_count++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0b, got %0b", want.found, got.found);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      fail_count++;
    end
    if (got.final_res !== want.final_res) begin
      $error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    triples_seen = 0;
    sets_closed = 0;
    set_len = 0;
    set_dropped = 1'b0;
    pending_triples = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        compare_result(out_data);
        if (out_data.found === 1'b1) triples_seen++;
      end
      if (in_valid && in_ready) begin
        if (set_len < SetDepth) begin
          set_vals[set_len] = in_data.value;
          set_len++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_data.last) close_set();
      end
      pending_triples = triple_q.size();
    end
  end

  final begin
    if (triple_q.size() != 0) begin
      $error("%0d results never arrived", triple_q.size());
    end
  end
endmodule

// ===== test/zero_sum_triple_finder_tb.sv =====
`timescale 1ns / 1ps
module zero_sum_triple_finder_tb;
  import ztf_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_triples;
  int        triples_seen;
  int        sets_closed;
  bit        steady = 1'b0;
  int        sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  zero_sum_triple_finder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  zero_sum_triple_finder_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_triples(pending_triples),
    .triples_seen(triples_seen), .sets_closed(sets_closed)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // hold each element until its transfer, with random gaps ahead of it
  task automatic push_elem(logic signed [VW-1:0] v, logic fin);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.value <= v;
    in_data.last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic push_set(int len, int span);
    for (int i = 0; i < len; i++) begin
      push_elem(span == 0 ? VW'($urandom) :
                VW'($urandom_range(2 * span) - span), i == len - 1);
    end
  endtask

  initial begin
    #2_000_000;
    $display("zero_sum_triple_finder_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // single element, then a pair: too few for a triple
    push_elem(16'sd5, 1'b1);
    push_elem(-16'sd5, 1'b0);
    push_elem(16'sd5, 1'b1);
    // extremes, zeros and duplicate anchors
    push_elem(16'sh8000, 1'b0);
    push_elem(16'sd32767, 1'b0);
    push_elem(16'sd1, 1'b0);
    push_elem(16'sd0, 1'b0);
    push_elem(16'sd0, 1'b0);
    push_elem(16'sd0, 1'b0);
    push_elem(-16'sd1, 1'b0);
    push_elem(-16'sd1, 1'b0);
    push_elem(16'sd2, 1'b1);
    // no zero sum among three
    push_elem(16'sd1, 1'b0);
    push_elem(16'sd2, 1'b0);
    push_elem(16'sd4, 1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    // pause until every result has drained
    while (pending_triples != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    // overfill the store; the final dropped element still closes the set
    steady = 1'b1;
    for (int i = 0; i < 34; i++) push_elem(VW'(i - 16), i == 33);
    steady = 1'b0;
    while (sent < 96) begin
      case ($urandom_range(3))
        0: push_set($urandom_range(3, 12), 0);
        1: push_set($urandom_range(3, 10), 8);
        2: push_set($urandom_range(6, 24), 20);
        default: push_set($urandom_range(1, 4), 3);
      endcase
      if ($urandom_range(9) == 0) steady = ~steady;
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk);
    while (pending_triples != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d elements in %0d sets, %0d zero-sum triples checked",
             sent, sets_closed, triples_seen);
    if (fail_count == 0 && pending_triples == 0) begin
      $display("zero_sum_triple_finder_tb: done, clean");
    end else begin
      $display("zero_sum_triple_finder_tb: done, errors");
    end
    $finish;
  end
endmodule

// ===== zero_sum_triple_finder.f =====
rtl/ztf_pkg.sv
rtl/ztf_res_fifo.sv
rtl/ztf_core.sv
rtl/zero_sum_triple_finder.sv
test/zero_sum_triple_finder_checker.sv
test/zero_sum_triple_finder_tb.sv
